/* rtl/ictsr_pkg.sv */
package ictsr_pkg;

    localparam logic [5:0] CAPTURE_BYTES     = 6'd40;
    localparam logic [5:0] MIN_MESSAGE_BYTES = 6'd20;
    localparam logic [7:0] TS_REPLY_TYPE     = 8'd14;
    localparam logic [15:0] SEQ_RESET        = 16'd10013;

    localparam int ORIG_W = 27;
    localparam int CFG_W  = ORIG_W;

    typedef enum logic [1:0] {
        CFG_ORIG_TIMESTAMP = 2'd0,
        CFG_EXPECTED_IDENT = 2'd1,
        CFG_EXPECTED_SEQ   = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        VERDICT_OK            = 3'd0,
        VERDICT_NOT_TS_REPLY  = 3'd1,
        VERDICT_TOO_SHORT     = 3'd2,
        VERDICT_ORIG_MISMATCH = 3'd3,
        VERDICT_ID_MISMATCH   = 3'd4,
        VERDICT_SEQ_MISMATCH  = 3'd5
    } t_verdict;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [31:0] receive_timestamp;
    } t_out_word;

    typedef struct packed {
        logic     step;
        t_in_word word;
    } t_parse_ctl;

    typedef struct packed {
        logic [5:0] byte_index;
    } t_parse_stat;

endpackage

/* rtl/ictsr_parser.sv */
module ictsr_parser
    import ictsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_parse_ctl         i_ctl,
    input  logic [ORIG_W-1:0]  i_orig_timestamp,
    input  logic [15:0]        i_expected_ident,
    input  logic [15:0]        i_expected_seq,
    output t_out_word          o_result,
    output t_parse_stat        o_stat
);

    logic [5:0]  r_idx,   n_idx,   u_idx;
    logic [3:0]  r_hdr,   n_hdr,   u_hdr;
    logic [7:0]  r_type,  n_type,  u_type;
    logic [31:0] r_orig,  n_orig,  u_orig;
    logic [15:0] r_ident, n_ident, u_ident;
    logic [15:0] r_seq,   n_seq,   u_seq;
    logic [31:0] r_recv,  n_recv,  u_recv;

    logic [3:0]  hw;
    logic [5:0]  start;
    logic [5:0]  rel;
    logic [5:0]  off;
    logic [5:0]  msg_len;
    logic [7:0]  b;
    t_verdict    verdict;

    assign b = i_ctl.word.data_byte;

    // Fold the current byte into the capture fields.
    always_comb begin
        u_idx   = r_idx;
        u_hdr   = r_hdr;
        u_type  = r_type;
        u_orig  = r_orig;
        u_ident = r_ident;
        u_seq   = r_seq;
        u_recv  = r_recv;
        hw      = (r_idx == 6'd0) ? b[3:0] : r_hdr;
        start   = {hw, 2'b00};
        rel     = r_idx - start;
        if (r_idx < CAPTURE_BYTES) begin
            if (r_idx == 6'd0) begin
                u_hdr = hw;
            end
            if (r_idx >= start) begin
                case (rel) inside
                    6'd0:           u_type  = b;
                    6'd4, 6'd5:     u_ident = {r_ident[7:0], b};
                    6'd6, 6'd7:     u_seq   = {r_seq[7:0], b};
                    [6'd8:6'd11]:   u_orig  = {r_orig[23:0], b};
                    [6'd12:6'd15]:  u_recv  = {r_recv[23:0], b};
                    default: ;
                endcase
            end
            u_idx = r_idx + 6'd1;
        end
    end

    // Verdict from the fields as they stand after this byte.
    always_comb begin
        off     = {u_hdr, 2'b00};
        msg_len = u_idx - off;
        if (u_idx < off || msg_len < MIN_MESSAGE_BYTES) begin
            verdict = VERDICT_TOO_SHORT;
        end else if (u_type != TS_REPLY_TYPE) begin
            verdict = VERDICT_NOT_TS_REPLY;
        end else if (u_orig != {{(32-ORIG_W){1'b0}}, i_orig_timestamp}) begin
            verdict = VERDICT_ORIG_MISMATCH;
        end else if (u_ident != i_expected_ident) begin
            verdict = VERDICT_ID_MISMATCH;
        end else if (u_seq != i_expected_seq) begin
            verdict = VERDICT_SEQ_MISMATCH;
        end else begin
            verdict = VERDICT_OK;
        end
        o_result.verdict           = verdict;
        o_result.receive_timestamp = (verdict == VERDICT_OK) ? u_recv : 32'd0;
    end

    always_comb begin
        n_idx   = r_idx;
        n_hdr   = r_hdr;
        n_type  = r_type;
        n_orig  = r_orig;
        n_ident = r_ident;
        n_seq   = r_seq;
        n_recv  = r_recv;
        if (i_ctl.step) begin
            if (i_ctl.word.last_byte) begin
                n_idx   = '0;
                n_hdr   = '0;
                n_type  = '0;
                n_orig  = '0;
                n_ident = '0;
                n_seq   = '0;
                n_recv  = '0;
            end else begin
                n_idx   = u_idx;
                n_hdr   = u_hdr;
                n_type  = u_type;
                n_orig  = u_orig;
                n_ident = u_ident;
                n_seq   = u_seq;
                n_recv  = u_recv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_hdr   <= '0;
            r_type  <= '0;
            r_orig  <= '0;
            r_ident <= '0;
            r_seq   <= '0;
            r_recv  <= '0;
        end else begin
            r_idx   <= n_idx;
            r_hdr   <= n_hdr;
            r_type  <= n_type;
            r_orig  <= n_orig;
            r_ident <= n_ident;
            r_seq   <= n_seq;
            r_recv  <= n_recv;
        end
    end

    assign o_stat.byte_index = r_idx;

endmodule

/* rtl/ictsr_outreg.sv */
module ictsr_outreg
    import ictsr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_word i_result,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    logic      r_valid, n_valid;
    t_out_word r_word,  n_word;

    always_comb begin
        n_valid = r_valid;
        n_word  = r_word;
        if (i_load) begin
            n_valid = 1'b1;
            n_word  = i_result;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

/* rtl/icmp_timestamp_reply_checker_core.sv */
// ICMP timestamp reply checker.
// Input channel (i_in_valid / o_in_ready / i_in_word): one word per packet byte,
// header first, last_byte set on the final byte of the packet. Only the first
// 40 bytes are examined; later bytes are accepted and ignored.
// Output channel (o_out_valid / i_out_ready / o_out_word): one verdict word per
// packet, produced by the final byte. receive_timestamp is zero unless the
// verdict is OK.
// Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we is high.
// Registers are sampled when the final byte is evaluated, so write them only
// between packets.
// Throughput is one byte per cycle, unless a final byte waits for the output
// register. A byte is held in the input register and evaluated there; o_out_valid
// rises when the final byte leaves the input register and loads its verdict.
// Reset clears the packet state and the output, and loads the configuration
// defaults (expected sequence 10013, others zero).
// When the receiver stalls, the held verdict stays put; non-final bytes keep
// flowing, and the next final byte waits in the input register until the
// output register frees up.
module icmp_timestamp_reply_checker_core
    import ictsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_word,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic [ORIG_W-1:0] r_orig_ts;
    logic [15:0]       r_exp_ident;
    logic [15:0]       r_exp_seq;

    logic      r_in_valid, n_in_valid;
    t_in_word  r_in_word,  n_in_word;

    logic        out_free;
    logic        advance;
    logic        load;
    t_parse_ctl  parse_ctl;
    t_out_word   result;
    t_parse_stat parse_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orig_ts   <= '0;
            r_exp_ident <= '0;
            r_exp_seq   <= SEQ_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ORIG_TIMESTAMP: r_orig_ts   <= i_cfg_data[ORIG_W-1:0];
                CFG_EXPECTED_IDENT: r_exp_ident <= i_cfg_data[15:0];
                CFG_EXPECTED_SEQ:   r_exp_seq   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // A held word moves on unless it is a final byte facing a full output.
    assign out_free   = !o_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!r_in_word.last_byte || out_free);
    assign load       = advance && r_in_word.last_byte;
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        n_in_valid = r_in_valid;
        n_in_word  = r_in_word;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
            n_in_word  = i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_word <= n_in_word;
    end

    assign parse_ctl.step = advance;
    assign parse_ctl.word = r_in_word;

    ictsr_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (parse_ctl),
        .i_orig_timestamp (r_orig_ts),
        .i_expected_ident (r_exp_ident),
        .i_expected_seq   (r_exp_seq),
        .o_result         (result),
        .o_stat           (parse_stat)
    );

    ictsr_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_result    (result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

`ifndef ASSERT_OFF
    a_byte_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        parse_stat.byte_index <= CAPTURE_BYTES)
        else $error("byte index ran past the capture window");

    a_recv_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.verdict != VERDICT_OK)
            |-> (o_out_word.receive_timestamp == 32'd0))
        else $error("receive timestamp set on a failed verdict");

    a_held_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_word)))
        else $error("stalled input word was lost or changed");

    a_index_clears_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (parse_stat.byte_index == 6'd0))
        else $error("packet state not cleared after final byte");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ictsr_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in_word         i_in_word = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_word        o_out_word;
    logic             i_cfg_we = 1'b0;
    logic [1:0]       i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    icmp_timestamp_reply_checker_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Register copies and per-packet capture state of the verdict predictor.
    logic [ORIG_W-1:0] reg_orig;
    logic [15:0]       reg_ident;
    logic [15:0]       reg_seq;
    logic [5:0]        seen_count;
    logic [3:0]        hdr_words;
    logic [7:0]        msg_type;
    logic [31:0]       got_orig;
    logic [15:0]       got_ident;
    logic [15:0]       got_seq;
    logic [31:0]       got_recv;

    t_out_word verdicts_due[$];
    t_out_word due_word;
    int        errors = 0;
    bit        no_idle = 1'b0;

    logic [7:0] pkt_buf [0:79];
    int         pkt_len;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic clear_capture();
        seen_count = '0;
        hdr_words  = '0;
        msg_type   = '0;
        got_orig   = '0;
        got_ident  = '0;
        got_seq    = '0;
        got_recv   = '0;
    endtask

    task automatic predictor_reset();
        reg_orig  = '0;
        reg_ident = '0;
        reg_seq   = SEQ_RESET;
        clear_capture();
    endtask

    task automatic predict_byte(input t_in_word w);
        int hw;
        int start;
        int rel;
        int len;
        int off;
        t_out_word due;
        if (seen_count < CAPTURE_BYTES) begin
            hw = (seen_count == 0) ? w.data_byte[3:0] : hdr_words;
            start = hw * 4;
            if (seen_count == 0) begin
                hdr_words = w.data_byte[3:0];
            end
            if (seen_count >= start) begin
                rel = seen_count - start;
                if (rel == 0) begin
                    msg_type = w.data_byte;
                end else if (rel == 4 || rel == 5) begin
                    got_ident = {got_ident[7:0], w.data_byte};
                end else if (rel == 6 || rel == 7) begin
                    got_seq = {got_seq[7:0], w.data_byte};
                end else if (rel >= 8 && rel <= 11) begin
                    got_orig = {got_orig[23:0], w.data_byte};
                end else if (rel >= 12 && rel <= 15) begin
                    got_recv = {got_recv[23:0], w.data_byte};
                end
            end
            seen_count = seen_count + 6'd1;
        end
        if (w.last_byte) begin
            len = seen_count;
            off = hdr_words * 4;
            due.receive_timestamp = '0;
            if (len < off || len - off < MIN_MESSAGE_BYTES) begin
                due.verdict = VERDICT_TOO_SHORT;
            end else if (msg_type != TS_REPLY_TYPE) begin
                due.verdict = VERDICT_NOT_TS_REPLY;
            end else if (got_orig != {5'd0, reg_orig}) begin
                due.verdict = VERDICT_ORIG_MISMATCH;
            end else if (got_ident != reg_ident) begin
                due.verdict = VERDICT_ID_MISMATCH;
            end else if (got_seq != reg_seq) begin
                due.verdict = VERDICT_SEQ_MISMATCH;
            end else begin
                due.verdict = VERDICT_OK;
                due.receive_timestamp = got_recv;
            end
            verdicts_due.push_back(due);
            clear_capture();
        end
    endtask

    function automatic bit take_gap();
        return !no_idle && ($urandom_range(0, 99) < 16);
    endfunction

    // Output side stalls at random except during the quiet stretch.
    always @(posedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("verdict word %0d with nothing pending",
                    o_out_word.verdict));
            end else begin
                due_word = verdicts_due.pop_front();
                if (o_out_word.verdict != due_word.verdict) begin
                    report_mismatch($sformatf("verdict %0d, predicted %0d",
                        o_out_word.verdict, due_word.verdict));
                end
                if (o_out_word.receive_timestamp != due_word.receive_timestamp) begin
                    report_mismatch($sformatf("receive timestamp %h, predicted %h",
                        o_out_word.receive_timestamp, due_word.receive_timestamp));
                end
            end
        end
    end

    // Valid is left high after acceptance unless a gap is taken, so that
    // back-to-back words never lower and raise it in the same step.
    task automatic send_word(input t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predict_byte(w);
        if (take_gap()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_range(input int first, input int stop);
        t_in_word w;
        for (int i = first; i < stop; i++) begin
            w.data_byte = pkt_buf[i];
            w.last_byte = (i == pkt_len - 1);
            send_word(w);
        end
    endtask

    task automatic send_packet();
        send_range(0, pkt_len);
    endtask

    // Waits until every verdict has been taken, then lets the pipeline settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_ORIG_TIMESTAMP: reg_orig = value;
            CFG_EXPECTED_IDENT: reg_ident = value[15:0];
            CFG_EXPECTED_SEQ:   reg_seq = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [ORIG_W-1:0] orig, input logic [15:0] ident,
                            input logic [15:0] seq);
        logic [31:0] r;
        r = $urandom;
        drain();
        // Unused upper data bits carry random junk; the block must drop them.
        write_reg(CFG_ORIG_TIMESTAMP, orig);
        write_reg(CFG_EXPECTED_IDENT, {r[10:0], ident});
        write_reg(CFG_EXPECTED_SEQ, {r[21:11], seq});
        i_cfg_we <= 1'b0;
    endtask

    // Fills the packet buffer: random filler, the message at 4 * IHL, and the
    // IHL nibble forced into byte 0 last, so with IHL 0 it shares the type byte.
    task automatic build_reply(input logic [3:0] ihl, input int len, input logic [7:0] mtype,
                               input logic [31:0] orig, input logic [15:0] ident,
                               input logic [15:0] seq, input logic [31:0] recv);
        int off;
        logic [31:0] r;
        logic [127:0] msg;
        off = ihl * 4;
        r = $urandom;
        msg = {mtype, r[7:0], r[31:16], ident, seq, orig, recv};
        pkt_len = len;
        for (int i = 0; i < len; i++) begin
            pkt_buf[i] = 8'($urandom);
        end
        for (int j = 0; j < 16; j++) begin
            if (off + j < len) begin
                pkt_buf[off + j] = msg[127 - 8 * j -: 8];
            end
        end
        pkt_buf[0][3:0] = ihl;
    endtask

    task automatic build_good(input logic [3:0] ihl, input int len, input logic [31:0] recv);
        build_reply(ihl, len, TS_REPLY_TYPE, {5'd0, reg_orig}, reg_ident, reg_seq, recv);
    endtask

    task automatic test_reset_defaults();
        build_good(4'd1, 24, 32'h1234_5678);
        send_packet();
    endtask

    task automatic test_verdict_codes();
        set_regs(27'd1234567, 16'hA55A, 16'h0F0F);
        build_reply(4'd1, 24, 8'd13, {5'd0, reg_orig}, reg_ident, reg_seq, $urandom);
        send_packet();
        build_reply(4'd1, 24, TS_REPLY_TYPE, {5'd0, reg_orig} + 32'd1, reg_ident, reg_seq,
                    $urandom);
        send_packet();
        build_reply(4'd1, 24, TS_REPLY_TYPE, {5'd0, reg_orig}, reg_ident ^ 16'h0001, reg_seq,
                    $urandom);
        send_packet();
        build_reply(4'd1, 24, TS_REPLY_TYPE, {5'd0, reg_orig}, reg_ident, reg_seq ^ 16'h8000,
                    $urandom);
        send_packet();
        build_good(4'd1, 23, $urandom);
        send_packet();
        // Earlier checks win when several fields are wrong at once.
        build_reply(4'd1, 14, 8'd0, 32'd7, 16'd1, 16'd2, $urandom);
        send_packet();
        build_reply(4'd1, 24, TS_REPLY_TYPE, 32'd7, 16'd1, 16'd2, $urandom);
        send_packet();
    endtask

    task automatic test_register_extremes();
        set_regs(27'd86399999, 16'hFFFF, 16'h0000);
        build_good(4'd1, 24, 32'hFFFF_FFFF);
        send_packet();
        set_regs(27'd0, 16'h0000, 16'hFFFF);
        build_good(4'd1, 24, 32'h0000_0000);
        send_packet();
    endtask

    task automatic test_wide_originate();
        set_regs(27'd86399999, 16'h1357, 16'h2468);
        build_reply(4'd1, 24, TS_REPLY_TYPE, {5'b00001, reg_orig}, reg_ident, reg_seq, $urandom);
        send_packet();
    endtask

    task automatic test_long_packets();
        build_good(4'd5, 41, $urandom);
        send_packet();
        // The message would be complete, but its tail lies past the capture window.
        build_good(4'd6, 44, $urandom);
        send_packet();
    endtask

    task automatic test_header_past_data();
        build_good(4'd15, 20, $urandom);
        send_packet();
        build_good(4'd5, 20, $urandom);
        send_packet();
    endtask

    task automatic test_small_ihl();
        build_reply(4'd0, 20, TS_REPLY_TYPE, {5'd0, reg_orig}, reg_ident, reg_seq, $urandom);
        send_packet();
        build_good(4'd3, 31, $urandom);
        send_packet();
    endtask

    task automatic test_runt_packets();
        build_good(4'd5, 1, $urandom);
        send_packet();
        build_reply(4'd0, 3, 8'd0, 32'd0, 16'd0, 16'd0, 32'd0);
        send_packet();
    endtask

    // The registers only matter once the final byte is evaluated.
    task automatic test_late_register_write();
        set_regs(27'd5, 16'h0101, 16'h0202);
        build_reply(4'd1, 24, TS_REPLY_TYPE, 32'd86399999, 16'hBEEF, 16'hCAFE, $urandom);
        send_range(0, pkt_len - 1);
        set_regs(27'd86399999, 16'hBEEF, 16'hCAFE);
        send_range(pkt_len - 1, pkt_len);
    endtask

    task automatic test_random_traffic();
        int n_bytes;
        int n_pkts;
        int k;
        int ihl;
        int off;
        int len;
        logic [31:0] r;
        logic [31:0] orig;
        logic [15:0] ident;
        logic [15:0] seq;
        logic [7:0]  mtype;
        for (int phase = 0; phase < 2; phase++) begin
            r = $urandom;
            if (phase == 0) begin
                set_regs(27'($urandom_range(0, 86399999)), r[15:0], r[31:16]);
            end else begin
                set_regs(27'd86399999, 16'hFFFF, 16'hFFFF);
            end
            no_idle = (phase == 1);
            n_bytes = 0;
            n_pkts = 0;
            while (n_pkts < 2 || n_bytes < 32 * (phase + 1)) begin
                k = $urandom_range(0, 99);
                ihl = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : 5;
                off = ihl * 4;
                len = ($urandom_range(0, 9) < 7) ? off + 20 : off + 20 + $urandom_range(1, 20);
                mtype = TS_REPLY_TYPE;
                orig = {5'd0, reg_orig};
                ident = reg_ident;
                seq = reg_seq;
                if (k < 55) begin
                    // Well-formed reply, half of them with exactly one bad field.
                    if ($urandom_range(0, 1) == 1) begin
                        case ($urandom_range(0, 3))
                            0: begin
                                r = $urandom_range(1, 255);
                                mtype = TS_REPLY_TYPE ^ r[7:0];
                            end
                            1: begin
                                r = $urandom_range(1, 31);
                                if ($urandom_range(0, 1) == 1) begin
                                    orig = orig ^ {r[4:0], 27'd0};
                                end else begin
                                    orig = orig ^ {5'd0, r[4:0], 22'd0} ^ 32'd1;
                                end
                            end
                            2: begin
                                r = $urandom_range(1, 65535);
                                ident = ident ^ r[15:0];
                            end
                            default: begin
                                r = $urandom_range(1, 65535);
                                seq = seq ^ r[15:0];
                            end
                        endcase
                    end
                end else if (k < 70) begin
                    len = $urandom_range(1, off + 19);
                end else begin
                    ihl = $urandom_range(0, 15);
                    len = $urandom_range(1, 60);
                    r = $urandom;
                    mtype = r[0] ? TS_REPLY_TYPE : r[15:8];
                    orig = $urandom;
                    ident = r[31:16];
                    seq = 16'($urandom);
                end
                build_reply(4'(ihl), len, mtype, orig, ident, seq, $urandom);
                send_packet();
                n_bytes += len;
                n_pkts++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        predictor_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_verdict_codes();
        test_register_extremes();
        test_wide_originate();
        test_long_packets();
        test_header_past_data();
        test_small_ihl();
        test_runt_packets();
        test_late_register_write();
        test_random_traffic();
        drain();
        repeat (8) @(posedge i_clk);
        if (verdicts_due.size() != 0) begin
            report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
        end
        if (errors == 0) begin
            $display("** icmp_timestamp_reply_checker_core: PASSED **");
        end else begin
            $display("** icmp_timestamp_reply_checker_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("** icmp_timestamp_reply_checker_core: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
rtl/ictsr_pkg.sv
rtl/ictsr_parser.sv
rtl/ictsr_outreg.sv
rtl/icmp_timestamp_reply_checker_core.sv
tb/tb_top.sv
